### rtl/i2cse_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C slave edge engine: store geometry, function and bus codes,
// protocol state encoding and the structs passed between modules. No dependencies.
package i2cse_pkg;

   // Store geometry
   localparam int BUF_DEPTH   = 32;
   localparam int BUF_ADDR_W  = $clog2(BUF_DEPTH);
   localparam int BUF_COUNT_W = $clog2(BUF_DEPTH + 1);

   // Event and host-access function codes
   localparam logic [2:0] FUNC_SCL_EDGE  = 3'd0;
   localparam logic [2:0] FUNC_SDA_EDGE  = 3'd1;
   localparam logic [2:0] FUNC_TX_WRITE  = 3'd2;
   localparam logic [2:0] FUNC_TX_LENGTH = 3'd3;
   localparam logic [2:0] FUNC_RX_READ   = 3'd4;
   localparam logic [2:0] FUNC_RX_CLEAR  = 3'd5;

   // Bus state codes reported on the result channel
   localparam logic [2:0] BUS_IDLE = 3'd0;
   localparam logic [2:0] BUS_ADDR = 3'd1;
   localparam logic [2:0] BUS_RECV = 3'd2;
   localparam logic [2:0] BUS_XMIT = 3'd3;
   localparam logic [2:0] BUS_WACK = 3'd4;

   // Protocol state, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADDR = 5'b00010,
      ST_RECV = 5'b00100,
      ST_XMIT = 5'b01000,
      ST_WACK = 5'b10000
   } proto_state_type;

   // One input transaction
   typedef struct packed {
      logic [2:0] func;
      logic       scl_level;
      logic       sda_level;
      logic [4:0] buffer_index;
      logic [7:0] write_data;
      logic [5:0] tx_length_in;
   } req_item_type;

   // One result transaction
   typedef struct packed {
      logic       sda_pull_low;
      logic [7:0] rx_data;
      logic [5:0] rx_count;
      logic [2:0] bus_state;
   } rsp_item_type;

   // Engine to store: write strobes and read addresses
   typedef struct packed {
      logic                  tx_we;
      logic [BUF_ADDR_W-1:0] tx_waddr;
      logic [7:0]            tx_wdata;
      logic [BUF_ADDR_W-1:0] tx_raddr;
      logic                  rx_we;
      logic [BUF_ADDR_W-1:0] rx_waddr;
      logic [7:0]            rx_wdata;
      logic [BUF_ADDR_W-1:0] rx_raddr;
   } store_ctl_type;

   // Map the one-hot protocol state to its reported code
   function automatic logic [2:0] bus_code(input proto_state_type st);
      logic [2:0] code;
      case (st)
         ST_IDLE: code = BUS_IDLE;
         ST_ADDR: code = BUS_ADDR;
         ST_RECV: code = BUS_RECV;
         ST_XMIT: code = BUS_XMIT;
         ST_WACK: code = BUS_WACK;
         default: code = BUS_IDLE;
      endcase
      return code;
   endfunction

endpackage

### rtl/i2cse_store.sv
`timescale 1ns / 1ps
// Transmit and receive byte stores of the I2C slave edge engine.
// Depends on i2cse_pkg for geometry and the control struct.
module i2cse_store (
   input  logic                    clock,
   input  logic                    reset,
   input  i2cse_pkg::store_ctl_type ctl,
   output logic [7:0]              tx_rdata,
   output logic [7:0]              rx_rdata
);
   import i2cse_pkg::*;

   logic [7:0]           tx_mem_ff [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] tx_valid_ff;
   logic [7:0]           rx_mem_ff [BUF_DEPTH];

   // Transmit store: entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_valid_ff <= '0;
      end else if (ctl.tx_we) begin
         tx_valid_ff[ctl.tx_waddr] <= 1'b1;
      end
      if (ctl.tx_we) begin
         tx_mem_ff[ctl.tx_waddr] <= ctl.tx_wdata;
      end
   end

   assign tx_rdata = tx_valid_ff[ctl.tx_raddr] ? tx_mem_ff[ctl.tx_raddr] : 8'h00;

   // Receive store: only entries below the fill count are ever read
   always_ff @(posedge clock) begin
      if (ctl.rx_we) begin
         rx_mem_ff[ctl.rx_waddr] <= ctl.rx_wdata;
      end
   end

   assign rx_rdata = rx_mem_ff[ctl.rx_raddr];

endmodule

### rtl/i2cse_engine.sv
`timescale 1ns / 1ps
// Protocol engine of the I2C slave: START/STOP, address match, receive and
// transmit shifting, ACK handling. Depends on i2cse_pkg; drives i2cse_store.
module i2cse_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  i2cse_pkg::req_item_type  item,
   input  logic [6:0]               own_address,
   input  logic [7:0]               tx_rdata,
   input  logic [7:0]               rx_rdata,
   output i2cse_pkg::store_ctl_type store_ctl,
   output i2cse_pkg::rsp_item_type  result
);
   import i2cse_pkg::*;

   proto_state_type        state_ff,        state_in;
   logic [3:0]             rx_bit_count_ff, rx_bit_count_in;
   logic [7:0]             rx_shift_ff,     rx_shift_in;
   logic [7:0]             tx_shift_ff,     tx_shift_in;
   logic [3:0]             tx_bit_count_ff, tx_bit_count_in;
   logic [BUF_COUNT_W-1:0] tx_position_ff,  tx_position_in;
   logic [BUF_COUNT_W-1:0] tx_count_ff,     tx_count_in;
   logic [BUF_COUNT_W-1:0] rx_fill_ff,      rx_fill_in;
   logic                   ack_due_ff,      ack_due_in;
   logic                   release_due_ff,  release_due_in;
   logic                   skip_ack_ff,     skip_ack_in;
   logic                   sda_out_ff,      sda_out_in;

   logic [BUF_COUNT_W-1:0] pos_adv;
   logic [7:0]             rx_data;

   // Next transmit position after a master ACK; stops at the length
   assign pos_adv = (tx_position_ff < tx_count_ff) ? tx_position_ff + 1'b1 : tx_position_ff;

   // Next-state logic for one transaction
   always_comb begin
      logic [7:0] shift_v;
      logic [3:0] cnt_v;

      state_in        = state_ff;
      rx_bit_count_in = rx_bit_count_ff;
      rx_shift_in     = rx_shift_ff;
      tx_shift_in     = tx_shift_ff;
      tx_bit_count_in = tx_bit_count_ff;
      tx_position_in  = tx_position_ff;
      tx_count_in     = tx_count_ff;
      rx_fill_in      = rx_fill_ff;
      ack_due_in      = ack_due_ff;
      release_due_in  = release_due_ff;
      skip_ack_in     = skip_ack_ff;
      sda_out_in      = sda_out_ff;
      rx_data         = 8'h00;
      shift_v         = {rx_shift_ff[6:0], item.sda_level};
      cnt_v           = rx_bit_count_ff + 4'd1;

      store_ctl          = '0;
      store_ctl.tx_waddr = item.buffer_index[BUF_ADDR_W-1:0];
      store_ctl.tx_wdata = item.write_data;
      store_ctl.tx_raddr = (state_ff == ST_ADDR) ? '0 : pos_adv[BUF_ADDR_W-1:0];
      store_ctl.rx_waddr = rx_fill_ff[BUF_ADDR_W-1:0];
      store_ctl.rx_wdata = shift_v;
      store_ctl.rx_raddr = item.buffer_index[BUF_ADDR_W-1:0];

      case (item.func)
         FUNC_SCL_EDGE: begin
            if (item.scl_level) begin
               // rising edge: sample SDA
               skip_ack_in = 1'b0;
               case (state_ff)
                  ST_ADDR: begin
                     if (cnt_v >= 4'd8) begin
                        if (shift_v[7:1] == own_address) begin
                           if (!shift_v[0]) begin
                              rx_fill_in = '0;
                              state_in   = ST_RECV;
                           end else begin
                              tx_position_in  = '0;
                              tx_shift_in     = (tx_count_ff != '0) ? tx_rdata : 8'hFF;
                              tx_bit_count_in = 4'd0;
                              state_in        = ST_XMIT;
                           end
                           ack_due_in = 1'b1;
                        end else begin
                           state_in = ST_IDLE;
                        end
                        rx_bit_count_in = 4'd0;
                        rx_shift_in     = 8'h00;
                     end else begin
                        rx_bit_count_in = cnt_v;
                        rx_shift_in     = shift_v;
                     end
                  end
                  ST_WACK: begin
                     // first edge is the last data bit's clock; next one is the ACK
                     if (!release_due_ff) begin
                        if (!item.sda_level) begin
                           tx_position_in  = pos_adv;
                           tx_shift_in     = (pos_adv < tx_count_ff) ? tx_rdata : 8'hFF;
                           tx_bit_count_in = 4'd0;
                           state_in        = ST_XMIT;
                        end else begin
                           state_in = ST_IDLE;
                        end
                     end
                  end
                  ST_RECV: begin
                     if (!skip_ack_ff) begin
                        if (cnt_v >= 4'd8) begin
                           if (rx_fill_ff < BUF_COUNT_W'(BUF_DEPTH)) begin
                              store_ctl.rx_we = fire;
                              rx_fill_in      = rx_fill_ff + 1'b1;
                           end
                           ack_due_in      = 1'b1;
                           rx_bit_count_in = 4'd0;
                           rx_shift_in     = 8'h00;
                        end else begin
                           rx_bit_count_in = cnt_v;
                           rx_shift_in     = shift_v;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end else begin
               // falling edge: change what we drive
               if (ack_due_ff) begin
                  sda_out_in     = 1'b1;
                  ack_due_in     = 1'b0;
                  release_due_in = 1'b1;
                  skip_ack_in    = 1'b1;
               end else if (state_ff == ST_XMIT && tx_count_ff != '0) begin
                  tx_shift_in     = {tx_shift_ff[6:0], 1'b0};
                  tx_bit_count_in = tx_bit_count_ff + 4'd1;
                  sda_out_in      = !tx_shift_ff[7];
                  if (tx_bit_count_in >= 4'd8) begin
                     release_due_in = 1'b1;
                     state_in       = ST_WACK;
                  end else begin
                     release_due_in = 1'b0;
                  end
               end else if (state_ff == ST_XMIT || release_due_ff) begin
                  sda_out_in     = 1'b0;
                  release_due_in = 1'b0;
               end
            end
         end
         FUNC_SDA_EDGE: begin
            // START or STOP while SCL is high
            if (item.scl_level) begin
               rx_bit_count_in = 4'd0;
               rx_shift_in     = 8'h00;
               if (!item.sda_level) begin
                  state_in = ST_ADDR;
               end else begin
                  state_in       = ST_IDLE;
                  tx_position_in = '0;
                  sda_out_in     = 1'b0;
               end
            end
         end
         FUNC_TX_WRITE: begin
            store_ctl.tx_we = fire;
         end
         FUNC_TX_LENGTH: begin
            tx_count_in    = (BUF_COUNT_W'(item.tx_length_in) > BUF_COUNT_W'(BUF_DEPTH))
                           ? BUF_COUNT_W'(BUF_DEPTH) : BUF_COUNT_W'(item.tx_length_in);
            tx_position_in = '0;
         end
         FUNC_RX_READ: begin
            if (BUF_COUNT_W'(item.buffer_index) < rx_fill_ff) begin
               rx_data = rx_rdata;
            end
         end
         FUNC_RX_CLEAR: begin
            rx_fill_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Result reflects state after the transaction
   assign result.sda_pull_low = sda_out_in;
   assign result.rx_data      = rx_data;
   assign result.rx_count     = 6'(rx_fill_in);
   assign result.bus_state    = bus_code(state_in);

   // Protocol state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rx_bit_count_ff <= '0;
         rx_shift_ff     <= '0;
         tx_shift_ff     <= '0;
         tx_bit_count_ff <= '0;
         tx_position_ff  <= '0;
         tx_count_ff     <= '0;
         rx_fill_ff      <= '0;
         ack_due_ff      <= 1'b0;
         release_due_ff  <= 1'b0;
         skip_ack_ff     <= 1'b0;
         sda_out_ff      <= 1'b0;
      end else if (fire) begin
         state_ff        <= state_in;
         rx_bit_count_ff <= rx_bit_count_in;
         rx_shift_ff     <= rx_shift_in;
         tx_shift_ff     <= tx_shift_in;
         tx_bit_count_ff <= tx_bit_count_in;
         tx_position_ff  <= tx_position_in;
         tx_count_ff     <= tx_count_in;
         rx_fill_ff      <= rx_fill_in;
         ack_due_ff      <= ack_due_in;
         release_due_ff  <= release_due_in;
         skip_ack_ff     <= skip_ack_in;
         sda_out_ff      <= sda_out_in;
      end
   end

endmodule

### rtl/i2c_slave_edge_engine_core.sv
`timescale 1ns / 1ps
// Top level of the I2C slave edge engine: input register, protocol engine,
// byte stores and result register. Depends on i2cse_pkg, i2cse_engine, i2cse_store.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | func, levels, index, data, length
//   rsp_    | out       | rsp_valid / rsp_stall | sda_pull_low, rx_data, rx_count, bus_state
//   csr_    | in        | csr_valid / csr_ready | own address (7 bits)
//
// One transaction per cycle sustained while rsp_stall is low; an accepted transaction
// passes the input register, then the combinational engine update and the result register.
// Synchronous reset clears all protocol state and the transmit-store valid bits
// with no clearing pass. rsp_stall holds the result register, and the
// input register still takes one more transaction before req_stall rises.
module i2c_slave_edge_engine_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_func,
   input  logic       req_scl_level,
   input  logic       req_sda_level,
   input  logic [4:0] req_buffer_index,
   input  logic [7:0] req_write_data,
   input  logic [5:0] req_tx_length_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_sda_pull_low,
   output logic [7:0] rsp_rx_data,
   output logic [5:0] rsp_rx_count,
   output logic [2:0] rsp_bus_state,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_write_data
);
   import i2cse_pkg::*;

   logic          item_valid_ff, item_valid_in;
   req_item_type  item_ff;
   logic          rsp_valid_ff,  rsp_valid_in;
   rsp_item_type  rsp_ff;
   logic [6:0]    own_address_ff;
   logic          fire;
   logic          req_take;
   store_ctl_type store_ctl;
   rsp_item_type  eng_result;
   logic [7:0]    tx_rdata;
   logic [7:0]    rx_rdata;

   // Handshake: the engine fires when the result register is free or draining
   assign fire          = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = item_valid_ff && !fire;
   assign req_take      = req_valid && !req_stall;
   assign item_valid_in = req_take || (item_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
   assign csr_ready     = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         own_address_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            own_address_ff <= csr_write_data;
         end
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func         <= req_func;
         item_ff.scl_level    <= req_scl_level;
         item_ff.sda_level    <= req_sda_level;
         item_ff.buffer_index <= req_buffer_index;
         item_ff.write_data   <= req_write_data;
         item_ff.tx_length_in <= req_tx_length_in;
      end
      if (fire) begin
         rsp_ff <= eng_result;
      end
   end

   i2cse_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (item_ff),
      .own_address (own_address_ff),
      .tx_rdata    (tx_rdata),
      .rx_rdata    (rx_rdata),
      .store_ctl   (store_ctl),
      .result      (eng_result)
   );

   i2cse_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .tx_rdata (tx_rdata),
      .rx_rdata (rx_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sda_pull_low = rsp_ff.sda_pull_low;
   assign rsp_rx_data      = rsp_ff.rx_data;
   assign rsp_rx_count     = rsp_ff.rx_count;
   assign rsp_bus_state    = rsp_ff.bus_state;

endmodule

### rtl/i2cse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the I2C slave edge engine and the bind that attaches them.
// Depends on i2c_slave_edge_engine_core port names.
module i2cse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_rx_data,
   input logic [5:0] rsp_rx_count
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rx_data) && $stable(rsp_rx_count))
      else $error("stalled result changed");

   // Receive fill never passes the store depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rx_count <= 6'd32)
      else $error("receive count beyond store depth");

   // An empty receive store never returns data
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_count == 6'd0 |-> rsp_rx_data == 8'h00)
      else $error("data read from empty receive store");

   // Input is only held off while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no waiting result");

endmodule

bind i2c_slave_edge_engine_core i2cse_checker u_i2cse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_rx_data  (rsp_rx_data),
   .rsp_rx_count (rsp_rx_count)
);

### tb/tb_i2c_slave_edge_engine_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_slave_edge_engine_core: drives directed and random
// bus events and host accesses, predicts each result with a scoreboard class.
// Depends on i2cse_pkg and the RTL of i2c_slave_edge_engine_core.
module tb_i2c_slave_edge_engine_core;
   import i2cse_pkg::*;

   // Function codes the block leaves unused
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 130;

   // Scoreboard: own copy of the slave state, predicts one result per event
   class edge_engine_scoreboard;
      logic [6:0] slave_address;
      logic [2:0] bus;
      logic [3:0] rx_bits;
      logic [7:0] rx_shift;
      logic [7:0] tx_shift;
      logic [3:0] tx_bits;
      logic [5:0] tx_pos;
      logic [5:0] tx_len;
      logic [7:0] tx_mem [BUF_DEPTH];
      logic [7:0] rx_mem [BUF_DEPTH];
      logic [5:0] rx_fill;
      bit         ack_due;
      bit         release_due;
      bit         skip_ack;
      bit         sda_low;
      rsp_item_type expected_results[$];
      int         errors;

      function new();
         errors = 0;
         slave_address = '0;
         bus = BUS_IDLE;
         rx_bits = '0;
         rx_shift = '0;
         tx_shift = '0;
         tx_bits = '0;
         tx_pos = '0;
         tx_len = '0;
         rx_fill = '0;
         ack_due = 0;
         release_due = 0;
         skip_ack = 0;
         sda_low = 0;
         foreach (tx_mem[i]) tx_mem[i] = '0;
         foreach (rx_mem[i]) rx_mem[i] = '0;
      endfunction

      function void set_address(logic [6:0] a);
         slave_address = a;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // SCL rising edge: sample address, data or the master's acknowledge
      function void scl_rise(bit sda);
         bit skipped;
         skipped = skip_ack;
         skip_ack = 0;
         case (bus)
            BUS_ADDR: begin
               rx_shift = {rx_shift[6:0], sda};
               rx_bits++;
               if (rx_bits >= 8) begin
                  if (rx_shift[7:1] == slave_address) begin
                     if (!rx_shift[0]) begin
                        rx_fill = '0;
                        bus = BUS_RECV;
                     end else begin
                        tx_pos = '0;
                        tx_shift = (tx_len != 0) ? tx_mem[0] : 8'hFF;
                        tx_bits = '0;
                        bus = BUS_XMIT;
                     end
                     ack_due = 1;
                  end else begin
                     bus = BUS_IDLE;
                  end
                  rx_bits = '0;
                  rx_shift = '0;
               end
            end
            BUS_WACK: begin
               // first rise after the last data bit belongs to that bit
               if (!release_due) begin
                  if (!sda) begin
                     if (tx_pos < tx_len) tx_pos++;
                     tx_shift = (tx_pos < tx_len) ? tx_mem[tx_pos[4:0]] : 8'hFF;
                     tx_bits = '0;
                     bus = BUS_XMIT;
                  end else begin
                     bus = BUS_IDLE;
                  end
               end
            end
            BUS_RECV: begin
               // the clock of our own ACK is not data
               if (!skipped) begin
                  rx_shift = {rx_shift[6:0], sda};
                  rx_bits++;
                  if (rx_bits >= 8) begin
                     if (rx_fill < BUF_DEPTH) begin
                        rx_mem[rx_fill[4:0]] = rx_shift;
                        rx_fill++;
                     end
                     ack_due = 1;
                     rx_bits = '0;
                     rx_shift = '0;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // SCL falling edge: drive ACK, next data bit, or release
      function void scl_fall();
         if (ack_due) begin
            sda_low = 1;
            ack_due = 0;
            release_due = 1;
            skip_ack = 1;
         end else if (bus == BUS_XMIT && tx_len != 0) begin
            sda_low = !tx_shift[7];
            tx_shift = tx_shift << 1;
            tx_bits++;
            if (tx_bits >= 8) begin
               release_due = 1;
               bus = BUS_WACK;
            end else begin
               release_due = 0;
            end
         end else if (bus == BUS_XMIT) begin
            sda_low = 0;
            release_due = 0;
         end else if (release_due) begin
            sda_low = 0;
            release_due = 0;
         end
      endfunction

      // Accepted input transaction: update state, queue the expected result
      function void note_event(req_item_type r);
         rsp_item_type exp_item;
         logic [7:0]   rdata;
         rdata = '0;
         case (r.func)
            FUNC_SCL_EDGE: begin
               if (r.scl_level) scl_rise(r.sda_level);
               else scl_fall();
            end
            FUNC_SDA_EDGE: begin
               if (r.scl_level) begin
                  rx_bits = '0;
                  rx_shift = '0;
                  if (!r.sda_level) begin
                     bus = BUS_ADDR;
                  end else begin
                     bus = BUS_IDLE;
                     tx_pos = '0;
                     sda_low = 0;
                  end
               end
            end
            FUNC_TX_WRITE: tx_mem[r.buffer_index] = r.write_data;
            FUNC_TX_LENGTH: begin
               tx_len = (r.tx_length_in > BUF_DEPTH) ? 6'(BUF_DEPTH) : r.tx_length_in;
               tx_pos = '0;
            end
            FUNC_RX_READ: begin
               if (r.buffer_index < rx_fill) rdata = rx_mem[r.buffer_index];
            end
            FUNC_RX_CLEAR: rx_fill = '0;
            default: ;
         endcase
         exp_item.sda_pull_low = sda_low;
         exp_item.rx_data = rdata;
         exp_item.rx_count = rx_fill;
         exp_item.bus_state = bus;
         expected_results.push_back(exp_item);
      endfunction

      function void compare_field(string name, logic [7:0] e, logic [7:0] g);
         if (g !== e) begin
            $error("%s mismatch: expected %0h, actual %0h", name, e, g);
            errors++;
         end
      endfunction

      // Accepted result transaction: compare with the oldest expectation
      function void check_result(rsp_item_type got);
         rsp_item_type exp_item;
         if (expected_results.size() == 0) begin
            $error("result with no expectation pending: %0h", got);
            errors++;
            return;
         end
         exp_item = expected_results.pop_front();
         compare_field("sda_pull_low", 8'(exp_item.sda_pull_low), 8'(got.sda_pull_low));
         compare_field("rx_data", exp_item.rx_data, got.rx_data);
         compare_field("rx_count", 8'(exp_item.rx_count), 8'(got.rx_count));
         compare_field("bus_state", 8'(exp_item.bus_state), 8'(got.bus_state));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_func;
   logic       req_scl_level;
   logic       req_sda_level;
   logic [4:0] req_buffer_index;
   logic [7:0] req_write_data;
   logic [5:0] req_tx_length_in;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_sda_pull_low;
   logic [7:0] rsp_rx_data;
   logic [5:0] rsp_rx_count;
   logic [2:0] rsp_bus_state;
   logic       csr_valid;
   logic       csr_ready;
   logic [6:0] csr_write_data;

   edge_engine_scoreboard sb = new();
   int items_sent = 0;
   int burst_left = 0;
   int stall_run = 0;
   int quiet_cycles = 0;

   i2c_slave_edge_engine_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_scl_level    (req_scl_level),
      .req_sda_level    (req_sda_level),
      .req_buffer_index (req_buffer_index),
      .req_write_data   (req_write_data),
      .req_tx_length_in (req_tx_length_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sda_pull_low (rsp_sda_pull_low),
      .rsp_rx_data      (rsp_rx_data),
      .rsp_rx_count     (rsp_rx_count),
      .rsp_bus_state    (rsp_bus_state),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_write_data   (csr_write_data)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern: free stretches, short stalls, a few long ones
   always @(negedge clock) begin : stall_gen
      int r;
      if (stall_run > 0) begin
         stall_run--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(1, 30);
         end else if (r < 88) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(0, 2);
         end else if (r < 98) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(3, 11);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(19, 59);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin : result_mon
      rsp_item_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.sda_pull_low = rsp_sda_pull_low;
         got.rx_data = rsp_rx_data;
         got.rx_count = rsp_rx_count;
         got.bus_state = rsp_bus_state;
         sb.check_result(got);
      end
   end

   // Watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Sender gap: mostly none, some short, a few long, with gap-free bursts
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_item_type random_item(logic [2:0] f);
      req_item_type it;
      it = req_item_type'($urandom);
      it.func = f;
      return it;
   endfunction

   // One input transaction, held until accepted
   task automatic send_req(req_item_type it);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= it.func;
      req_scl_level <= it.scl_level;
      req_sda_level <= it.sda_level;
      req_buffer_index <= it.buffer_index;
      req_write_data <= it.write_data;
      req_tx_length_in <= it.tx_length_in;
      do @(posedge clock); while (req_stall);
      sb.note_event(it);
      items_sent++;
   endtask

   task automatic scl_event(bit level, bit sda);
      req_item_type it;
      it = random_item(FUNC_SCL_EDGE);
      it.scl_level = level;
      it.sda_level = sda;
      send_req(it);
   endtask

   task automatic sda_event(bit scl, bit sda);
      req_item_type it;
      it = random_item(FUNC_SDA_EDGE);
      it.scl_level = scl;
      it.sda_level = sda;
      send_req(it);
   endtask

   task automatic host_op(logic [2:0] f, logic [4:0] idx, logic [7:0] d, logic [5:0] len);
      req_item_type it;
      it = random_item(f);
      it.buffer_index = idx;
      it.write_data = d;
      it.tx_length_in = len;
      send_req(it);
   endtask

   // Sender idles until every expected result is back
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_address(logic [6:0] a);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_write_data <= a;
      do @(posedge clock); while (!csr_ready);
      sb.set_address(a);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic bus_start();
      sda_event(1'b1, 1'b0);
      scl_event(1'b0, $urandom_range(0, 1));
   endtask

   // From SCL high: lower SCL, raise it with SDA low, then SDA rises
   task automatic bus_stop();
      scl_event(1'b0, $urandom_range(0, 1));
      scl_event(1'b1, 1'b0);
      sda_event(1'b1, 1'b1);
   endtask

   // Eight data clocks from the master plus the ACK clock
   task automatic send_byte_acked(logic [7:0] b);
      for (int i = 7; i >= 0; i--) begin
         scl_event(1'b1, b[i]);
         scl_event(1'b0, $urandom_range(0, 1));
      end
      scl_event(1'b1, 1'b0);
      scl_event(1'b0, $urandom_range(0, 1));
   endtask

   task automatic write_transfer(logic [6:0] addr, int nbytes);
      bus_start();
      send_byte_acked({addr, 1'b0});
      repeat (nbytes) send_byte_acked(8'($urandom));
      if ($urandom_range(0, 5) != 0) begin
         scl_event(1'b1, 1'b0);
         sda_event(1'b1, 1'b1);
      end
   endtask

   task automatic load_tx_store();
      int len;
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) host_op(FUNC_TX_WRITE, 5'(i), 8'($urandom), 6'($urandom));
      host_op(FUNC_TX_LENGTH, 5'($urandom), 8'($urandom), 6'(len));
   endtask

   task automatic read_transfer(logic [6:0] addr, int nbytes);
      bit nack;
      bus_start();
      for (int i = 7; i >= 0; i--) begin
         scl_event(1'b1, i == 0 ? 1'b1 : addr[i-1]);
         scl_event(1'b0, $urandom_range(0, 1));
      end
      scl_event(1'b1, 1'b0);
      for (int k = 0; k < nbytes; k++) begin
         repeat (8) begin
            scl_event(1'b0, $urandom_range(0, 1));
            scl_event(1'b1, $urandom_range(0, 1));
         end
         scl_event(1'b0, $urandom_range(0, 1));
         nack = (k == nbytes - 1) || ($urandom_range(0, 9) == 0);
         scl_event(1'b1, nack);
         if (nack) break;
      end
      if ($urandom_range(0, 5) != 0) bus_stop();
   endtask

   task automatic host_burst();
      int n;
      int r;
      n = $urandom_range(1, 6);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            host_op(FUNC_TX_WRITE, $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) :
                    5'($urandom), 8'($urandom), 6'($urandom));
         end else if (r < 50) begin
            r = $urandom_range(0, 19);
            host_op(FUNC_TX_LENGTH, 5'($urandom), 8'($urandom),
                    r < 14 ? 6'($urandom_range(0, 5)) :
                    r < 17 ? 6'($urandom_range(6, 31)) : 6'($urandom_range(32, 63)));
         end else if (r < 85) begin
            host_op(FUNC_RX_READ, $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) :
                    5'($urandom), 8'($urandom), 6'($urandom));
         end else if (r < 93) begin
            host_op(FUNC_RX_CLEAR, 5'($urandom), 8'($urandom), 6'($urandom));
         end else begin
            send_req(random_item($urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B));
         end
      end
   endtask

   // Broken sequence: start, part of a byte, then stop or another start
   task automatic broken_transfer();
      int nbits;
      bus_start();
      nbits = $urandom_range(1, 7);
      repeat (nbits) begin
         scl_event(1'b1, $urandom_range(0, 1));
         scl_event(1'b0, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 1)) begin
         scl_event(1'b1, 1'b0);
         sda_event(1'b1, 1'b1);
      end else begin
         scl_event(1'b1, 1'b1);
         sda_event(1'b1, 1'b0);
      end
   endtask

   task automatic random_action(logic [6:0] own);
      logic [6:0] addr;
      int r;
      addr = ($urandom_range(0, 9) < 8) ? own : 7'($urandom);
      r = $urandom_range(0, 99);
      if (r < 35) begin
         write_transfer(addr, $urandom_range(0, 3));
      end else if (r < 65) begin
         if ($urandom_range(0, 1)) load_tx_store();
         read_transfer(addr, $urandom_range(1, 4));
      end else if (r < 78) begin
         host_burst();
      end else if (r < 88) begin
         repeat ($urandom_range(1, 6)) begin
            send_req(random_item($urandom_range(0, 3) != 0 ? 3'($urandom_range(0, 1)) :
                                 3'($urandom)));
         end
      end else if (r < 97) begin
         broken_transfer();
      end else begin
         wait_drain();
      end
   endtask

   // Main sequence
   initial begin : main
      logic [6:0] phase_addr;
      int phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_RX_READ;
      req_scl_level = 1'b0;
      req_sda_level = 1'b0;
      req_buffer_index = '0;
      req_write_data = '0;
      req_tx_length_in = '0;
      csr_valid = 1'b0;
      csr_write_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, unused codes, ignored edges, start and stop
      host_op(FUNC_RX_READ, 5'd0, 8'h00, 6'd0);
      send_req(random_item(FUNC_SPARE_A));
      send_req(random_item(FUNC_SPARE_B));
      sda_event(1'b0, 1'b0);
      sda_event(1'b0, 1'b1);
      scl_event(1'b1, 1'b1);
      scl_event(1'b0, 1'b0);
      host_op(FUNC_TX_LENGTH, 5'd0, 8'h00, 6'd63);
      host_op(FUNC_TX_LENGTH, 5'd31, 8'hFF, 6'd32);
      host_op(FUNC_TX_LENGTH, 5'd0, 8'h00, 6'd0);
      host_op(FUNC_TX_WRITE, 5'd0, 8'hFF, 6'd0);
      host_op(FUNC_TX_WRITE, 5'd31, 8'h00, 6'd63);
      host_op(FUNC_TX_WRITE, 5'd31, 8'hFF, 6'd0);
      host_op(FUNC_RX_READ, 5'd31, 8'hFF, 6'd63);
      host_op(FUNC_RX_CLEAR, 5'd0, 8'h00, 6'd0);
      sda_event(1'b1, 1'b0);
      sda_event(1'b1, 1'b1);
      wait_drain();

      // Random phases, one address setting each
      for (int p = 0; p < 5; p++) begin
         phase_addr = (p == 0) ? 7'h7F : (p == 1) ? 7'h00 : 7'($urandom_range(1, 126));
         write_own_address(phase_addr);
         phase_start = items_sent;
         // receive store overflow: one byte more than it holds
         if (p == 0) write_transfer(phase_addr, BUF_DEPTH + 1);
         while (items_sent - phase_start < PHASE_ITEMS) random_action(phase_addr);
         wait_drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
rtl/i2cse_pkg.sv
rtl/i2cse_store.sv
rtl/i2cse_engine.sv
rtl/i2c_slave_edge_engine_core.sv
rtl/i2cse_checker.sv
tb/tb_i2c_slave_edge_engine_core.sv
